// ===== rtl/afl_pkg.sv =====
`timescale 1ns / 1ps

package afl_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned BUFFER_DEPTH_DEF = 1024;
    localparam int unsigned SINE_DEPTH_DEF   = 256;

    // Field and datapath widths
    localparam int unsigned SMP_W     = 16;
    localparam int unsigned ST_W      = 24;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned MA_W      = 33;
    localparam int unsigned MB_W      = 25;
    localparam int unsigned ACC_W     = MA_W + MB_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX   = 3'd4;

    // Register reset values
    localparam logic [9:0]  MAX_DELAY_RST = 10'd240;
    localparam logic [31:0] LFO_STEP_RST  = 32'd44739;
    localparam logic [14:0] FEEDBACK_RST  = 15'd22938;
    localparam logic [15:0] WET_MIX_RST   = 16'd16384;
    localparam logic [15:0] MIX_FULL      = 16'd32768;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    // Multiplier operand selects
    typedef enum logic [2:0] {
        ASEL_ZERO,
        ASEL_PHASE,
        ASEL_LFO,
        ASEL_INV_F,
        ASEL_FRAC,
        ASEL_FB,
        ASEL_MIX,
        ASEL_INV_MIX
    } asel_t;

    typedef enum logic [2:0] {
        BSEL_ZERO,
        BSEL_TDEPTH,
        BSEL_MAXD,
        BSEL_MEMQ,
        BSEL_DELAYED,
        BSEL_WET,
        BSEL_X16
    } bsel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    // Register-transfer actions of one step
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ROM_ADDR,
        ACT_SPLIT,
        ACT_WRAP,
        ACT_RD_NEAR,
        ACT_RD_FAR,
        ACT_DELAYED,
        ACT_WET,
        ACT_STORE,
        ACT_OUT_FX,
        ACT_OUT_PASS
    } act_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_IF_WRAP,
        JMP_DONE
    } jump_t;

    // Program addresses
    typedef enum logic [4:0] {
        U_IDX_MUL   = 5'd0,
        U_IDX       = 5'd1,
        U_ROM_WAIT  = 5'd2,
        U_DEPTH_MUL = 5'd3,
        U_SPLIT     = 5'd4,
        U_WRAP      = 5'd5,
        U_RD_NEAR   = 5'd6,
        U_RD_FAR    = 5'd7,
        U_INTERP_A  = 5'd8,
        U_INTERP_B  = 5'd9,
        U_DELAYED   = 5'd10,
        U_FB_MUL    = 5'd11,
        U_WET       = 5'd12,
        U_MIX_WET   = 5'd13,
        U_MIX_DRY   = 5'd14,
        U_OUT_FX    = 5'd15,
        U_OUT_PASS  = 5'd16
    } step_t;

    typedef struct packed {
        asel_t   asel;
        bsel_t   bsel;
        acc_op_t acc_op;
        act_t    act;
        jump_t   jmp;
        step_t   target;
    } uword_t;

    // Sequencer to datapath
    typedef struct packed {
        uword_t uw;
        logic   exec;
        logic   clear;
        logic   take;
    } seq_ctl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic fx_enable;
        logic wrap_pending;
        logic clear_last;
        logic out_busy;
    } dp_stat_t;

    function automatic uword_t mk_uw(asel_t a, bsel_t b, acc_op_t o, act_t t,
                                     jump_t j, step_t tg);
        uword_t w;
        w.asel   = a;
        w.bsel   = b;
        w.acc_op = o;
        w.act    = t;
        w.jmp    = j;
        w.target = tg;
        return w;
    endfunction

    // Control store: one word per step
    function automatic uword_t ucode(step_t s);
        uword_t w;
        unique case (s)
            U_IDX_MUL:   w = mk_uw(ASEL_PHASE, BSEL_TDEPTH, ACC_LOAD, ACT_NONE,
                                   JMP_NEXT, U_IDX_MUL);
            U_IDX:       w = mk_uw(ASEL_ZERO, BSEL_ZERO, ACC_HOLD, ACT_ROM_ADDR,
                                   JMP_NEXT, U_IDX_MUL);
            U_ROM_WAIT:  w = mk_uw(ASEL_ZERO, BSEL_ZERO, ACC_HOLD, ACT_NONE,
                                   JMP_NEXT, U_IDX_MUL);
            U_DEPTH_MUL: w = mk_uw(ASEL_LFO, BSEL_MAXD, ACC_LOAD, ACT_NONE,
                                   JMP_NEXT, U_IDX_MUL);
            U_SPLIT:     w = mk_uw(ASEL_ZERO, BSEL_ZERO, ACC_HOLD, ACT_SPLIT,
                                   JMP_NEXT, U_IDX_MUL);
            U_WRAP:      w = mk_uw(ASEL_ZERO, BSEL_ZERO, ACC_HOLD, ACT_WRAP,
                                   JMP_IF_WRAP, U_WRAP);
            U_RD_NEAR:   w = mk_uw(ASEL_ZERO, BSEL_ZERO, ACC_HOLD, ACT_RD_NEAR,
                                   JMP_NEXT, U_IDX_MUL);
            U_RD_FAR:    w = mk_uw(ASEL_ZERO, BSEL_ZERO, ACC_HOLD, ACT_RD_FAR,
                                   JMP_NEXT, U_IDX_MUL);
            U_INTERP_A:  w = mk_uw(ASEL_INV_F, BSEL_MEMQ, ACC_LOAD, ACT_NONE,
                                   JMP_NEXT, U_IDX_MUL);
            U_INTERP_B:  w = mk_uw(ASEL_FRAC, BSEL_MEMQ, ACC_ADD, ACT_NONE,
                                   JMP_NEXT, U_IDX_MUL);
            U_DELAYED:   w = mk_uw(ASEL_ZERO, BSEL_ZERO, ACC_HOLD, ACT_DELAYED,
                                   JMP_NEXT, U_IDX_MUL);
            U_FB_MUL:    w = mk_uw(ASEL_FB, BSEL_DELAYED, ACC_LOAD, ACT_NONE,
                                   JMP_NEXT, U_IDX_MUL);
            U_WET:       w = mk_uw(ASEL_ZERO, BSEL_ZERO, ACC_HOLD, ACT_WET,
                                   JMP_NEXT, U_IDX_MUL);
            U_MIX_WET:   w = mk_uw(ASEL_MIX, BSEL_WET, ACC_LOAD, ACT_STORE,
                                   JMP_NEXT, U_IDX_MUL);
            U_MIX_DRY:   w = mk_uw(ASEL_INV_MIX, BSEL_X16, ACC_ADD, ACT_NONE,
                                   JMP_NEXT, U_IDX_MUL);
            U_OUT_FX:    w = mk_uw(ASEL_ZERO, BSEL_ZERO, ACC_HOLD, ACT_OUT_FX,
                                   JMP_DONE, U_IDX_MUL);
            U_OUT_PASS:  w = mk_uw(ASEL_ZERO, BSEL_ZERO, ACC_HOLD, ACT_OUT_PASS,
                                   JMP_DONE, U_IDX_MUL);
            default:     w = mk_uw(ASEL_ZERO, BSEL_ZERO, ACC_HOLD, ACT_NONE,
                                   JMP_DONE, U_IDX_MUL);
        endcase
        return w;
    endfunction

    // Sine table entry for an angle in 1/65536 turns (elaboration only)
    function automatic logic [15:0] lfo_entry(logic [15:0] ang);
        logic [1:0]        q;
        logic [63:0]       t;
        logic [63:0]       u;
        logic [63:0]       u2;
        logic [63:0]       inner;
        logic [63:0]       mid;
        logic [63:0]       r;
        logic signed [31:0] v;
        q = ang[15:14];
        t = {50'd0, ang[13:0]};
        if (q[0])
            t = 64'd16384 - t;
        u     = t << 2;
        u2    = (u * u) >> 16;
        inner = 64'd42334 - ((u2 * 64'd5223) >> 16);
        mid   = 64'd102944 - ((u2 * inner) >> 16);
        r     = (u * mid) >> 16;
        if (r > 64'd65536)
            r = 64'd65536;
        if (!q[1])
            v = 32'sd32768 + $signed(r[32:1]);
        else
            v = 32'sd32768 - $signed(r[32:1]);
        if (v > 32'sd65535)
            v = 32'sd65535;
        if (v < 32'sd0)
            v = 32'sd0;
        return v[15:0];
    endfunction

endpackage

// ===== rtl/afl_lfo_rom.sv =====
`timescale 1ns / 1ps

module afl_lfo_rom import afl_pkg::*; #(
    parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr,
    output logic [15:0]                         data
);

    logic [15:0] rom_tab [SINE_TABLE_DEPTH];

    // Constant sine table, one entry per phase slot
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_tab
        localparam logic [15:0] ANGLE = 16'((k * 65536) / SINE_TABLE_DEPTH);
        assign rom_tab[k] = lfo_entry(ANGLE);
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        data <= rom_tab[addr];
    end

endmodule

// ===== rtl/afl_dp.sv =====
`timescale 1ns / 1ps

module afl_dp import afl_pkg::*; #(
    parameter int unsigned BUFFER_DEPTH     = BUFFER_DEPTH_DEF,
    parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_idx,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic signed [SMP_W-1:0] sample_in,
    input  seq_ctl_t                ctl,
    input  logic                    out_ready,
    output dp_stat_t                stat,
    output logic                    out_valid,
    output logic signed [SMP_W-1:0] sample_out
);

    localparam int unsigned AW   = $clog2(BUFFER_DEPTH);
    localparam int unsigned IW   = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned PW   = 17;
    localparam int unsigned IDXW = ACC_W - 32;
    localparam logic [PW-1:0] DEPTH_P = PW'(BUFFER_DEPTH);

    // Configuration registers
    logic        fx_en_reg;
    logic [9:0]  maxd_reg;
    logic [31:0] lfo_step_reg;
    logic [14:0] fb_reg;
    logic [15:0] mix_reg;

    // Control state
    logic [AW-1:0] wp_reg;
    logic [31:0]   phase_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          out_valid_reg;

    // Working registers
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic [IW-1:0]           rom_addr_reg;
    logic [9:0]              d_reg;
    logic [15:0]             f_reg;
    logic [AW-1:0]           rd_addr_reg;
    logic [ST_W-1:0]         delayed_reg;
    logic [ST_W-1:0]         wet_reg;
    logic signed [SMP_W-1:0] x_reg;
    logic signed [SMP_W-1:0] out_data_reg;

    logic [15:0]     rom_q;
    logic [ST_W-1:0] mem_q;
    logic [ST_W-1:0] store_mem [BUFFER_DEPTH];
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [ST_W-1:0] mem_wd;

    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [ACC_W-1:0] prod;
    logic [16:0]             inv_f;
    logic [15:0]             mix_eff;
    logic [15:0]             inv_mix;
    logic [IDXW-1:0]         idx_hi;
    logic [PW-1:0]           wp_w;
    logic [PW-1:0]           d_w;
    logic [PW-1:0]           i1_w;
    logic signed [25:0]      wet_sum;
    logic [ST_W-1:0]         wet_sat;
    logic signed [20:0]      out_full;
    logic signed [SMP_W-1:0] out_sat;
    logic                    wrap_pending;
    logic                    store_go;
    logic                    out_go;

    afl_lfo_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_lfo_rom (
        .clk  (clk),
        .addr (rom_addr_reg),
        .data (rom_q)
    );

    // Operand preparation
    always_comb
    begin
        mix_eff = (mix_reg > MIX_FULL) ? MIX_FULL : mix_reg;
        inv_mix = MIX_FULL - mix_eff;
        inv_f   = 17'h10000 - {1'b0, f_reg};
        idx_hi  = acc_reg[ACC_W-1:32];
        wp_w    = PW'(wp_reg);
        d_w     = {7'd0, d_reg};
        i1_w    = (wp_w >= d_w) ? (wp_w - d_w) : (wp_w + DEPTH_P - d_w);
        wrap_pending = (d_w >= DEPTH_P);
    end

    // Shared multiplier and accumulator
    always_comb
    begin
        unique case (ctl.uw.asel)
            ASEL_PHASE:   mul_a = {1'b0, phase_reg};
            ASEL_LFO:     mul_a = {17'd0, rom_q};
            ASEL_INV_F:   mul_a = {16'd0, inv_f};
            ASEL_FRAC:    mul_a = {17'd0, f_reg};
            ASEL_FB:      mul_a = {18'd0, fb_reg};
            ASEL_MIX:     mul_a = {17'd0, mix_eff};
            ASEL_INV_MIX: mul_a = {17'd0, inv_mix};
            default:      mul_a = '0;
        endcase
        unique case (ctl.uw.bsel)
            BSEL_TDEPTH:  mul_b = MB_W'(SINE_TABLE_DEPTH);
            BSEL_MAXD:    mul_b = {15'd0, maxd_reg};
            BSEL_MEMQ:    mul_b = {mem_q[ST_W-1], mem_q};
            BSEL_DELAYED: mul_b = {delayed_reg[ST_W-1], delayed_reg};
            BSEL_WET:     mul_b = {wet_reg[ST_W-1], wet_reg};
            BSEL_X16:     mul_b = {{5{x_reg[SMP_W-1]}}, x_reg, 4'd0};
            default:      mul_b = '0;
        endcase
        prod = mul_a * mul_b;
        acc_next = acc_reg;
        if (ctl.exec)
        begin
            unique case (ctl.uw.acc_op)
                ACC_LOAD: acc_next = prod;
                ACC_ADD:  acc_next = acc_reg + prod;
                default:  acc_next = acc_reg;
            endcase
        end
    end

    // Wet value and output saturation
    always_comb
    begin
        wet_sum = {{6{x_reg[SMP_W-1]}}, x_reg, 4'd0} + {acc_reg[39], acc_reg[39:15]};
        if (wet_sum > 26'sd8388607)
            wet_sat = 24'h7FFFFF;
        else if (wet_sum < -26'sd8388608)
            wet_sat = 24'h800000;
        else
            wet_sat = wet_sum[ST_W-1:0];
        out_full = acc_reg[39:19];
        if (out_full > 21'sd32767)
            out_sat = 16'sh7FFF;
        else if (out_full < -21'sd32768)
            out_sat = 16'sh8000;
        else
            out_sat = out_full[SMP_W-1:0];
    end

    assign store_go = ctl.exec && (ctl.uw.act == ACT_STORE);
    assign out_go   = ctl.exec && ((ctl.uw.act == ACT_OUT_FX) ||
                                   (ctl.uw.act == ACT_OUT_PASS));

    // Config registers, pointers, clearing counter, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_en_reg     <= 1'b0;
            maxd_reg      <= MAX_DELAY_RST;
            lfo_step_reg  <= LFO_STEP_RST;
            fb_reg        <= FEEDBACK_RST;
            mix_reg       <= WET_MIX_RST;
            wp_reg        <= '0;
            phase_reg     <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_ENABLE:    fx_en_reg    <= cfg_data[0];
                    CFG_MAX_DELAY: maxd_reg     <= cfg_data[9:0];
                    CFG_LFO_STEP:  lfo_step_reg <= cfg_data[31:0];
                    CFG_FEEDBACK:  fb_reg       <= cfg_data[14:0];
                    CFG_WET_MIX:   mix_reg      <= cfg_data[15:0];
                    default:       ;
                endcase
            end
            if (ctl.clear)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            if (store_go)
            begin
                wp_reg    <= (wp_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                phase_reg <= phase_reg + lfo_step_reg;
            end
            if (out_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (ctl.take)
            x_reg <= sample_in;
        if (ctl.exec)
        begin
            unique case (ctl.uw.act)
                ACT_ROM_ADDR:
                begin
                    rom_addr_reg <= (idx_hi >= IDXW'(SINE_TABLE_DEPTH)) ?
                                    IW'(SINE_TABLE_DEPTH - 1) : idx_hi[IW-1:0];
                end
                ACT_SPLIT:
                begin
                    d_reg <= acc_reg[25:16];
                    f_reg <= acc_reg[15:0];
                end
                ACT_WRAP:
                begin
                    if (wrap_pending)
                        d_reg <= d_reg - 10'(BUFFER_DEPTH);
                end
                ACT_RD_NEAR:  rd_addr_reg <= i1_w[AW-1:0];
                ACT_RD_FAR:
                begin
                    rd_addr_reg <= (rd_addr_reg == '0) ? AW'(BUFFER_DEPTH - 1)
                                                       : rd_addr_reg - AW'(1);
                end
                ACT_DELAYED:  delayed_reg  <= acc_reg[39:16];
                ACT_WET:      wet_reg      <= wet_sat;
                ACT_OUT_FX:   out_data_reg <= out_sat;
                ACT_OUT_PASS: out_data_reg <= x_reg;
                default:      ;
            endcase
        end
    end

    // Delay store: clearing sweep or wet write-back, registered read
    always_comb
    begin
        mem_we = ctl.clear || store_go;
        mem_wa = ctl.clear ? clr_addr_reg : wp_reg;
        mem_wd = ctl.clear ? '0 : wet_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_wa] <= mem_wd;
        mem_q <= store_mem[rd_addr_reg];
    end

    // Status back to the sequencer
    always_comb
    begin
        stat.fx_enable    = fx_en_reg;
        stat.wrap_pending = wrap_pending;
        stat.clear_last   = (clr_addr_reg == AW'(BUFFER_DEPTH - 1));
        stat.out_busy     = out_valid_reg && !out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

endmodule

// ===== rtl/afl_seq.sv =====
`timescale 1ns / 1ps

module afl_seq import afl_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output seq_ctl_t ctl
);

    seq_state_t state_reg;
    seq_state_t state_next;
    step_t      step_reg;
    step_t      step_next;
    uword_t     uw;
    logic       stall;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= U_IDX_MUL;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Control word fetch, sequencing and jumps
    always_comb
    begin
        uw         = ucode(step_reg);
        stall      = (uw.jmp == JMP_DONE) && stat.out_busy;
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        ctl.uw     = uw;
        ctl.exec   = 1'b0;
        ctl.clear  = 1'b0;
        ctl.take   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear = 1'b1;
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.take   = 1'b1;
                    state_next = ST_RUN;
                    step_next  = stat.fx_enable ? U_IDX_MUL : U_OUT_PASS;
                end
            end
            ST_RUN:
            begin
                ctl.exec = !stall;
                unique case (uw.jmp)
                    JMP_NEXT:    step_next = step_t'(step_reg + 5'd1);
                    JMP_IF_WRAP: step_next = stat.wrap_pending ? uw.target
                                                               : step_t'(step_reg + 5'd1);
                    JMP_DONE:
                    begin
                        if (!stall)
                            state_next = ST_IDLE;
                    end
                    default:     state_next = ST_IDLE;
                endcase
            end
            default: state_next = ST_CLEAR;
        endcase
    end

endmodule

// ===== rtl/audio_flanger_core.sv =====
`timescale 1ns / 1ps

// Flanger core: LFO-swept fractional delay with feedback, one sample in, one out.
// Input channel in_valid/in_ready carries sample_in; output channel
// out_valid/out_ready carries sample_out; a transfer happens when both are high.
// Registers are written through cfg_we/cfg_idx/cfg_data; the user must write
// them only while the core is idle; the core itself does not enforce this.
// With the effect enabled a sample runs a 16-step microprogram on one shared
// 33x25 multiplier: its last step sets sample_out, and the next sample can be
// taken once that step has run. When the integer delay reaches BUFFER_DEPTH,
// the wrap step repeats, subtracting BUFFER_DEPTH each time (never when
// BUFFER_DEPTH >= 1024). With the effect disabled the pass-through step copies
// the sample. After reset the delay store is swept to zero, one entry per cycle,
// over all BUFFER_DEPTH entries; in_ready stays low during that sweep.
// A result waits in the output register while the receiver stalls; a new sample
// is still taken, and its program holds on the last step until the register frees.

module audio_flanger_core import afl_pkg::*; #(
    parameter int unsigned BUFFER_DEPTH     = BUFFER_DEPTH_DEF,
    parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_idx,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [SMP_W-1:0] sample_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SMP_W-1:0] sample_out
);

    seq_ctl_t ctl;
    dp_stat_t stat;

    afl_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    afl_dp #(
        .BUFFER_DEPTH     (BUFFER_DEPTH),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .ctl        (ctl),
        .out_ready  (out_ready),
        .stat       (stat),
        .out_valid  (out_valid),
        .sample_out (sample_out)
    );

    // One sample at a time: busy right after an input transfer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a sample is in progress");

    // No traffic during the clearing sweep
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |-> !in_ready && !out_valid)
        else $error("channel active during store clearing");

    // A new result only comes from an executed program step
    a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctl.exec))
        else $error("result appeared without a program step");

    // Final step never overwrites a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.uw.jmp == JMP_DONE) && out_valid && !out_ready |-> !ctl.exec)
        else $error("pending result overwritten");

endmodule

// ===== bench/audio_flanger_core_tb.sv =====
`timescale 1ns / 1ps

module audio_flanger_core_tb;
    import afl_pkg::*;

    localparam int unsigned BUFFER_DEPTH    = BUFFER_DEPTH_DEF;
    localparam int unsigned SINE_DEPTH      = SINE_DEPTH_DEF;
    localparam int unsigned ADDR_W          = $clog2(BUFFER_DEPTH);
    localparam int          RESET_CYCLES    = 10;
    localparam int          DRAIN_CYCLES    = 32;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          QUIET_LIMIT     = 5000;
    localparam int          MAX_REPORTS     = 100;
    localparam int          RANDOM_PHASES   = 12;
    localparam int          PHASE_ITEMS     = 60;
    localparam longint      FRAC_ONE        = 65536;
    localparam longint      WET_MAX         = 8388607;
    localparam longint      WET_MIN         = -8388608;
    localparam longint      OUT_MAX         = 32767;
    localparam longint      OUT_MIN         = -32768;

    typedef logic signed [SMP_W-1:0] sample_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_THIRD,
        RX_SPARSE
    } rx_style_t;

    typedef enum int {
        SS_UNIFORM,
        SS_EXTREME,
        SS_LOUD,
        SS_QUIET
    } sample_style_t;

    // Bench-side drive, all known from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    sample_t              sample_in = '0;
    logic                 out_ready = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    sample_t              sample_out;

    // Shadow of the core's settings and state
    logic                    fx_on;
    logic [9:0]              depth_reg;
    logic [31:0]             step_reg;
    logic [14:0]             fb_reg;
    logic [15:0]             mix_reg;
    logic signed [ST_W-1:0]  echo_mem [BUFFER_DEPTH];
    logic [ADDR_W-1:0]       head_ptr;
    logic [31:0]             sweep_phase;
    logic [15:0]             sine_lut [SINE_DEPTH];

    // Results still owed by the core, oldest first
    sample_t pending_out[$];

    int  mismatch_count = 0;
    int  result_index   = 0;
    int  quiet_cycles   = 0;
    int  burst_left     = 0;
    int  tone_left      = 0;
    bit  tone_neg       = 1'b0;
    bit  hold_off_req   = 1'b0;

    audio_flanger_core #(
        .BUFFER_DEPTH     (BUFFER_DEPTH),
        .SINE_TABLE_DEPTH (SINE_DEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    always #1 clk = ~clk;

    // Quarter-wave polynomial sine, offset into 0..65535
    function automatic logic [15:0] sine_point(input int unsigned k);
        longint unsigned ang;
        longint unsigned quad;
        longint unsigned t;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned inner;
        longint unsigned mid;
        longint unsigned r;
        longint unsigned v;
        ang = ((64'(k) * 64'd65536) / SINE_DEPTH) & 64'hFFFF;
        quad = ang >> 14;
        t = ang & 64'h3FFF;
        if (quad[0])
            t = 64'd16384 - t;
        u     = t << 2;
        u2    = (u * u) >> 16;
        inner = 64'd42334 - ((u2 * 64'd5223) >> 16);
        mid   = 64'd102944 - ((u2 * inner) >> 16);
        r     = (u * mid) >> 16;
        if (r > 64'd65536)
            r = 64'd65536;
        if (quad < 2)
            v = 64'd32768 + (r >> 1);
        else
            v = 64'd32768 - (r >> 1);
        if (v > 64'd65535)
            v = 64'd65535;
        return v[15:0];
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Expected output for one sample; advances the shadow state when the effect is on
    function automatic sample_t flange_sample(input sample_t x);
        logic [15:0]       lfo;
        logic [31:0]       prod;
        logic [ADDR_W-1:0] d;
        logic [ADDR_W-1:0] near_i;
        logic [ADDR_W-1:0] far_i;
        longint            frac;
        longint            x16;
        longint            dly;
        longint            wet;
        longint            mix;
        longint            acc;
        longint            o;
        if (!fx_on)
            return x;
        lfo    = sine_lut[(64'(sweep_phase) * SINE_DEPTH) >> 32];
        prod   = 32'(lfo) * 32'(depth_reg);
        d      = ADDR_W'((prod >> 16) % BUFFER_DEPTH);
        frac   = longint'(prod[15:0]);
        near_i = head_ptr - d;
        far_i  = near_i - ADDR_W'(1);
        dly    = (longint'(echo_mem[near_i]) * (FRAC_ONE - frac)
                  + longint'(echo_mem[far_i]) * frac) >>> 16;
        x16    = longint'(x) * 16;
        wet    = clip(x16 + ((longint'(fb_reg) * dly) >>> 15), WET_MIN, WET_MAX);
        mix    = (mix_reg > MIX_FULL) ? longint'(MIX_FULL) : longint'(mix_reg);
        acc    = mix * wet + (longint'(MIX_FULL) - mix) * x16;
        o      = clip(acc >>> 19, OUT_MIN, OUT_MAX);
        echo_mem[head_ptr] = wet[ST_W-1:0];
        head_ptr    = head_ptr + ADDR_W'(1);
        sweep_phase = sweep_phase + step_reg;
        return o[SMP_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input sample_t got, input sample_t want);
        mismatch_count++;
        // keep the log readable if the core is badly off
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] result %0d: %s, got %0d want %0d",
                     $time, result_index, what, got, want);
    endtask

    // Upper bits above the register width are junk half the time
    function automatic logic [CFG_W-1:0] with_noise(input logic [CFG_W-1:0] v, input int w);
        logic [CFG_W-1:0] r;
        r = $urandom();
        if ($urandom_range(0, 1) == 0)
            r = '0;
        r = (r << w) | v;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_ENABLE:    fx_on     = data[0];
            CFG_MAX_DELAY: depth_reg = data[9:0];
            CFG_LFO_STEP:  step_reg  = data[31:0];
            CFG_FEEDBACK:  fb_reg    = data[14:0];
            CFG_WET_MIX:   mix_reg   = data[15:0];
            default:       ;
        endcase
    endtask

    // One input transfer, in bursts with random gaps between them
    task automatic send_sample(input sample_t s);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_out.push_back(flange_sample(s));
    endtask

    // Stop offering and wait until the core has nothing left in flight
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic sample_t pick_sample(input sample_style_t st);
        int mag;
        if ($urandom_range(0, 5) == 0)
            st = SS_UNIFORM;
        case (st)
            SS_EXTREME:
            begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    3:       return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
            end
            SS_LOUD:
            begin
                // long same-sign runs drive the feedback loop into saturation
                if (tone_left == 0)
                begin
                    tone_left = $urandom_range(8, 64);
                    tone_neg  = ~tone_neg;
                end
                tone_left--;
                mag = $urandom_range(24000, 32767);
                return tone_neg ? sample_t'(-mag - 1) : sample_t'(mag);
            end
            SS_QUIET:
                return sample_t'(int'($urandom_range(0, 31)) - 16);
            default:
                return sample_t'($urandom());
        endcase
    endfunction

    task automatic randomise_settings(input int phase_i);
        logic [CFG_W-1:0] en;
        logic [CFG_W-1:0] dly;
        logic [CFG_W-1:0] step;
        logic [CFG_W-1:0] fb;
        logic [CFG_W-1:0] mix;
        case (phase_i)
            0:
            begin
                en = 1; dly = 1023; step = 32'hFFFF_FFFF; fb = 32767; mix = 32'h0000_FFFF;
            end
            1:
            begin
                en = 1; dly = 0; step = 0; fb = 0; mix = 0;
            end
            default:
            begin
                en = 32'($urandom_range(0, 4) != 0);
                case ($urandom_range(0, 3))
                    0:       dly = 0;
                    1:       dly = 1023;
                    2:       dly = $urandom_range(1, 8);
                    default: dly = $urandom_range(0, 1023);
                endcase
                case ($urandom_range(0, 3))
                    0:       step = 0;
                    1:       step = $urandom_range(0, 1 << 20);
                    2:       step = 32'hFFFF_FFFF - $urandom_range(0, 255);
                    default: step = $urandom();
                endcase
                case ($urandom_range(0, 3))
                    0:       fb = 0;
                    1:       fb = 32767;
                    2:       fb = $urandom_range(30000, 32767);
                    default: fb = $urandom_range(0, 32767);
                endcase
                case ($urandom_range(0, 3))
                    0:       mix = 0;
                    1:       mix = 32'(MIX_FULL);
                    2:       mix = $urandom_range(32769, 65535);
                    default: mix = $urandom_range(0, 32768);
                endcase
            end
        endcase
        write_reg(CFG_ENABLE,    with_noise(en, 1));
        write_reg(CFG_MAX_DELAY, with_noise(dly, 10));
        write_reg(CFG_LFO_STEP,  step);
        write_reg(CFG_FEEDBACK,  with_noise(fb, 15));
        write_reg(CFG_WET_MIX,   with_noise(mix, 16));
    endtask

    // ---------------------------------------------------------------- tests

    // Reset defaults leave the effect off: samples copy straight through
    task automatic test_passthrough();
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
    endtask

    // Enable bit is masked to one bit; effect runs with the reset settings
    task automatic test_enable_masked();
        wait_drained();
        write_reg(CFG_ENABLE, 32'hFFFF_FFFE);
        send_sample(16'sh1234);
        wait_drained();
        write_reg(CFG_ENABLE, 32'h0000_0003);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh3039);
    endtask

    // No delay reads the oldest entry; mix above one acts as all wet
    task automatic test_zero_delay();
        wait_drained();
        write_reg(CFG_MAX_DELAY, 32'h0);
        write_reg(CFG_FEEDBACK,  32'h7FFF);
        write_reg(CFG_WET_MIX,   32'hFFFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
    endtask

    // Writes to unmapped indexes must leave every setting alone
    task automatic test_unmapped_index();
        int i;
        wait_drained();
        for (i = CFG_WET_MIX + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(i[CFG_IDX_W-1:0], $urandom());
        send_sample(16'sh4321);
    endtask

    // Park the LFO at phase zero, delay of exactly one sample, near-unity feedback:
    // the store and then the output both clip
    task automatic test_wet_saturation();
        int n;
        wait_drained();
        write_reg(CFG_LFO_STEP, 32'd0 - sweep_phase);
        send_sample(16'sh0100);
        wait_drained();
        write_reg(CFG_LFO_STEP,  32'h0);
        write_reg(CFG_MAX_DELAY, 32'd2);
        write_reg(CFG_FEEDBACK,  32'h7FFF);
        write_reg(CFG_WET_MIX,   32'(MIX_FULL));
        for (n = 0; n < 18; n++)
            send_sample(16'sh7FFF);
    endtask

    // Receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        int n;
        wait_drained();
        randomise_settings(RANDOM_PHASES);
        write_reg(CFG_ENABLE, 32'h1);
        hold_off_req = 1'b1;
        for (n = 0; n < 10; n++)
            send_sample(pick_sample(SS_UNIFORM));
    endtask

    task automatic test_random_sweeps();
        int            phase_i;
        int            n;
        sample_style_t style;
        for (phase_i = 0; phase_i < RANDOM_PHASES; phase_i++)
        begin
            wait_drained();
            randomise_settings(phase_i);
            style = sample_style_t'($urandom_range(0, 3));
            for (n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample(style));
        end
    endtask

    // ------------------------------------------------------------ processes

    // Receiver pacing: segments of open, coin-flip, every third and sparse ready
    initial
    begin : rx_pacer
        int        seg_len;
        int        k;
        rx_style_t style;
        forever
        begin
            if (hold_off_req)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            seg_len = $urandom_range(4, 40);
            style   = rx_style_t'($urandom_range(0, 3));
            for (k = 0; k < seg_len; k++)
            begin
                @(negedge clk);
                case (style)
                    RX_OPEN:  out_ready <= 1'b1;
                    RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
                    RX_THIRD: out_ready <= (k % 3 == 0);
                    default:  out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Output transfers against the oldest owed result
    always @(posedge clk)
    begin : out_check
        sample_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_out.size() == 0)
            begin
                report_mismatch("no result pending", sample_out, '0);
            end
            else
            begin
                want = pending_out.pop_front();
                if (sample_out !== want)
                    report_mismatch("sample_out", sample_out, want);
            end
            result_index++;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        for (int k = 0; k < SINE_DEPTH; k++)
            sine_lut[k] = sine_point(k);
        for (int k = 0; k < BUFFER_DEPTH; k++)
            echo_mem[k] = '0;
        head_ptr    = '0;
        sweep_phase = '0;
        fx_on       = 1'b0;
        depth_reg   = MAX_DELAY_RST;
        step_reg    = LFO_STEP_RST;
        fb_reg      = FEEDBACK_RST;
        mix_reg     = WET_MIX_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_passthrough();
        test_enable_masked();
        test_zero_delay();
        test_unmapped_index();
        test_wet_saturation();
        test_backpressure();
        test_random_sweeps();
        wait_drained();

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
